[sv/drum_trigger_velocity_detect_defines.svh]
// Assertion macros used by the checker file.
`ifndef DRUM_TRIGGER_VELOCITY_DETECT_DEFINES_SVH
`define DRUM_TRIGGER_VELOCITY_DETECT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTVD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dtvd check failed");

// next-cycle implication, sampled on clk, off during reset
`define DTVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dtvd check failed");

`endif

[sv/dtvd_pkg.sv]
package dtvd_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int VEL_BITS        = 7;
	localparam int MS_BITS         = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int DIV_CNT_W       = 3;

	localparam logic [MS_BITS-1:0] MS_MAX = '1;

	// phase codes
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TRACK = 2'd1;
	localparam logic [1:0] PH_MASK  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET      = 3'd3;

	// register reset values
	localparam int THRESHOLD_RST  = 100;
	localparam int FULL_SCALE_RST = 1023;
	localparam logic [MS_BITS-1:0] WINDOW_RST = 8'd10;
	localparam logic [MS_BITS-1:0] QUIET_RST  = 8'd30;

endpackage

[sv/dtvd_div.sv]
// Bit-serial restoring divider: quot = (diff * 127) / den.
// One quotient bit per cycle, MSB first; diff <= den keeps quot below 128.
module dtvd_div import dtvd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [SAMPLE_BITS-1:0] diff,
	input  logic [SAMPLE_BITS-1:0] den,
	output logic                   done,
	output logic [VEL_BITS-1:0]    quot
);

	localparam int NW = SAMPLE_BITS + VEL_BITS;

	logic [NW-1:0]        rem_q;
	logic [NW-1:0]        den_sh_q;
	logic [VEL_BITS-1:0]  quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 fits;

	assign fits = rem_q >= den_sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(VEL_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// x*127 = (x << 7) - x
			rem_q    <= {diff, {VEL_BITS{1'b0}}} - {{VEL_BITS{1'b0}}, diff};
			den_sh_q <= {1'b0, den, {(VEL_BITS-1){1'b0}}};
			quot_q   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - den_sh_q;
			end
			quot_q   <= {quot_q[VEL_BITS-2:0], fits};
			den_sh_q <= den_sh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[sv/drum_trigger_velocity_detect.sv]
// Channel  | Dir | Signals                          | Payload (lowest bit up)
// s_axis   | in  | tvalid tready tdata tuser        | tdata: sample; tuser: kind
// m_axis   | out | tvalid tready tdata              | tdata: velocity, peak_level
// cfg      | in  | valid ready index data           | index 0..7 (0..3 mapped), data: register value
//
// Ticks and ordinary samples leave tready high.
// The sample that closes the peak window holds tready low: a prep step to
// clamp and load, the bit-serial divider (one quotient bit a cycle), then a step
// to hand the hit on; it waits while the output register is still full.
// Reset (arst_n low) restores register defaults, idle phase and empty output.
// A waiting result does not stop input transfers; only a new hit waits for it.
module drum_trigger_velocity_detect import dtvd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample
	input  logic                     s_axis_tuser,          // kind (1 = ms tick)
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [((VEL_BITS+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // velocity, peak_level
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SAMPLE_BITS-1:0]   cfg_data
);

	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((VEL_BITS + SAMPLE_BITS + 7) / 8) * 8;

	// sequencer states
	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	// config registers
	logic [SAMPLE_BITS-1:0] thr_q;
	logic [SAMPLE_BITS-1:0] full_q;
	logic [MS_BITS-1:0]     window_q;
	logic [MS_BITS-1:0]     quiet_q;

	// trigger state
	logic [1:0]             phase_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [MS_BITS-1:0]     elapsed_q;
	logic [1:0]             state_q;

	// output register
	logic                   out_valid_q;
	logic [VEL_BITS-1:0]    out_vel_q;
	logic [SAMPLE_BITS-1:0] out_peak_q;

	logic                   in_xfer;
	logic                   is_tick;
	logic [SAMPLE_BITS-1:0] smp;
	logic [SAMPLE_BITS-1:0] peak_max;
	logic [SAMPLE_BITS-1:0] clamped;
	logic [SAMPLE_BITS-1:0] diff;
	logic [SAMPLE_BITS-1:0] den;
	logic                   div_start;
	logic                   div_done;
	logic [VEL_BITS-1:0]    div_quot;
	logic                   out_free;
	logic                   out_load;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign is_tick  = s_axis_tuser;
	assign smp      = s_axis_tdata[SAMPLE_BITS-1:0];
	assign peak_max = (smp > peak_q) ? smp : peak_q;

	// clamp held peak to [threshold, full scale]; only used when full > thr
	always_comb begin
		if (peak_q < thr_q) begin
			clamped = thr_q;
		end else if (peak_q > full_q) begin
			clamped = full_q;
		end else begin
			clamped = peak_q;
		end
	end

	assign diff      = clamped - thr_q;
	assign den       = full_q - thr_q;
	assign div_start = (state_q == ST_PREP) && (full_q > thr_q);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign out_load  = (state_q == ST_DIV) && div_done && (div_quot != '0) && out_free;

	assign s_axis_tready = (state_q == ST_RUN);
	assign cfg_ready     = 1'b1;

	// config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= SAMPLE_BITS'(THRESHOLD_RST);
			full_q   <= SAMPLE_BITS'(FULL_SCALE_RST);
			window_q <= WINDOW_RST;
			quiet_q  <= QUIET_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD:  thr_q    <= cfg_data;
				REG_FULL_SCALE: full_q   <= cfg_data;
				REG_WINDOW:     window_q <= cfg_data[MS_BITS-1:0];
				REG_QUIET:      quiet_q  <= cfg_data[MS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// phase tracking and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			peak_q    <= '0;
			elapsed_q <= '0;
			state_q   <= ST_RUN;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (in_xfer) begin
						if (is_tick) begin
							if (elapsed_q != MS_MAX) begin
								elapsed_q <= elapsed_q + 1'b1;
							end
						end else begin
							case (phase_q)
								PH_IDLE: begin
									if (smp > thr_q) begin
										phase_q   <= PH_TRACK;
										peak_q    <= smp;
										elapsed_q <= '0;
									end
								end
								PH_TRACK: begin
									peak_q <= peak_max;
									if (elapsed_q >= window_q) begin
										// window closed: take velocity
										phase_q   <= PH_MASK;
										elapsed_q <= '0;
										state_q   <= ST_PREP;
									end
								end
								default: begin
									// mask (unused code 3 behaves the same)
									if (smp > thr_q) begin
										elapsed_q <= '0;
									end else if (elapsed_q > quiet_q) begin
										phase_q <= PH_IDLE;
									end
								end
							endcase
						end
					end
				end
				ST_PREP: begin
					// degenerate scale gives velocity 0: no hit
					state_q <= div_start ? ST_DIV : ST_RUN;
				end
				ST_DIV: begin
					if (div_done && ((div_quot == '0) || out_free)) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_vel_q  <= div_quot;
			out_peak_q <= peak_q;
		end
	end

	dtvd_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.diff  (diff),
		.den   (den),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'({out_peak_q, out_vel_q});

	// upper tdata pad bits are ignored
	logic unused_pad;
	assign unused_pad = ^{1'b0, s_axis_tdata[IN_W-1:0]};

endmodule

[sv/dtvd_checker.sv]
`include "drum_trigger_velocity_detect_defines.svh"

module dtvd_checker import dtvd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_axis_tvalid,
	input logic                     s_axis_tready,
	input logic                     s_axis_tuser,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [((VEL_BITS+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

	// a hit always carries a nonzero velocity
	`DTVD_ASSERT_NOW(a_vel_nonzero, clk, arst_n, m_axis_tvalid, m_axis_tdata[VEL_BITS-1:0] != '0)

	// a stalled result holds
	`DTVD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a new result is only produced while the input side is held off
	`DTVD_ASSERT_NOW(a_hit_blocks_in, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tready))

	// a tick transfer never starts a divide
	`DTVD_ASSERT_NEXT(a_tick_no_stall, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, s_axis_tready)

endmodule

bind drum_trigger_velocity_detect dtvd_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_dtvd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

[verif/tb_drum_trigger_velocity_detect.sv]
module tb_drum_trigger_velocity_detect;
	import dtvd_pkg::*;

	localparam int SMP_W    = SAMPLE_BITS_DEF;
	localparam int IN_W     = ((SMP_W + 7) / 8) * 8;
	localparam int OUT_W    = ((VEL_BITS + SMP_W + 7) / 8) * 8;
	localparam int LVL_MAX  = (1 << SMP_W) - 1;
	localparam int VEL_MAX  = (1 << VEL_BITS) - 1;
	localparam int DRAIN    = 24;      // margin for the block to finish a closing sample
	localparam int LIMIT    = 500000;  // cycle budget for the whole run
	localparam int MAX_SHOW = 10;

	// kind codes carried on s_axis_tuser
	localparam bit KIND_SAMPLE = 1'b0;
	localparam bit KIND_TICK   = 1'b1;

	typedef struct packed {
		logic [VEL_BITS-1:0] velocity;
		logic [SMP_W-1:0]    peak_level;
	} hit_t;

	// Tracks the trigger state machine and holds the hits still owed by the block.
	class hit_scoreboard;
		logic [SMP_W-1:0]   thr   = THRESHOLD_RST;
		logic [SMP_W-1:0]   full  = FULL_SCALE_RST;
		logic [MS_BITS-1:0] win   = WINDOW_RST;
		logic [MS_BITS-1:0] quiet = QUIET_RST;
		logic [1:0]         phase = PH_IDLE;
		logic [SMP_W-1:0]   peak  = '0;
		logic [MS_BITS-1:0] elapsed = '0;
		hit_t               pending[$];
		int                 errors = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SMP_W-1:0] data);
			case (idx)
				REG_THRESHOLD:  thr   = data;
				REG_FULL_SCALE: full  = data;
				REG_WINDOW:     win   = data[MS_BITS-1:0];
				REG_QUIET:      quiet = data[MS_BITS-1:0];
				default: ;  // unmapped index, dropped
			endcase
		endfunction

		// one accepted input transfer
		function void note_item(bit kind, logic [SMP_W-1:0] s);
			int unsigned lo, hi, x, vel;
			hit_t h;
			if (kind == KIND_TICK) begin
				if (elapsed != MS_MAX)
					elapsed++;
				return;
			end
			case (phase)
				PH_IDLE: begin
					if (s > thr) begin
						phase   = PH_TRACK;
						peak    = s;
						elapsed = '0;
					end
				end
				PH_TRACK: begin
					if (s > peak)
						peak = s;
					if (elapsed >= win) begin
						lo  = thr;
						hi  = full;
						x   = peak;
						vel = 0;
						if (hi > lo) begin
							if (x < lo) x = lo;
							if (x > hi) x = hi;
							vel = ((x - lo) * VEL_MAX) / (hi - lo);
						end
						phase   = PH_MASK;
						elapsed = '0;
						if (vel > 0) begin
							h.velocity   = vel[VEL_BITS-1:0];
							h.peak_level = peak;
							pending.push_back(h);
						end
					end
				end
				default: begin  // mask, and the unused code behaves the same
					if (s > thr)
						elapsed = '0;
					else if (elapsed > quiet)
						phase = PH_IDLE;
				end
			endcase
		endfunction

		function void flag(string what, int exp_v, int act_v);
			errors++;
			if (errors <= MAX_SHOW)
				$display("mismatch %0s: expected %0d, got %0d", what, exp_v, act_v);
		endfunction

		// one accepted output transfer
		function void check_hit(logic [OUT_W-1:0] word);
			hit_t h;
			logic [VEL_BITS-1:0] vel;
			logic [SMP_W-1:0]    pk;
			vel = word[VEL_BITS-1:0];
			pk  = word[VEL_BITS +: SMP_W];
			if (pending.size() == 0) begin
				flag("unexpected hit, velocity", -1, vel);
				return;
			end
			h = pending.pop_front();
			if (vel != h.velocity)
				flag("velocity", h.velocity, vel);
			if (pk != h.peak_level)
				flag("peak_level", h.peak_level, pk);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;   // sample
	logic                  s_axis_tuser;   // kind
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;   // velocity, peak_level
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [SMP_W-1:0]      cfg_data;

	hit_scoreboard sb = new;
	int  sent = 0;
	int  cycle_count = 0;
	bit  calm = 0;   // set for the closing stretch: no idling on either side

	drum_trigger_velocity_detect dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the block hangs
	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Output side: check each hit transfer, stall in random bursts.
	initial begin
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_hit(m_axis_tdata);
			@(negedge clk);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				stall--;
			end else if (!calm && $urandom_range(7, 0) == 0) begin
				m_axis_tready = 1'b0;
				stall = $urandom_range(17, 1) - 1;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	function automatic int lo_level();
		return $urandom_range(sb.thr, 0);
	endfunction

	function automatic int hi_level();
		if (sb.thr == LVL_MAX)
			return LVL_MAX;
		return $urandom_range(LVL_MAX, sb.thr + 1);
	endfunction

	// One input transfer, optionally after an idle gap.
	task automatic send_item(input bit kind, input int level);
		int gap;
		if (!calm && $urandom_range(4, 0) == 0) begin
			gap = $urandom_range(17, 1);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = '0;
		s_axis_tdata[SMP_W-1:0] = level[SMP_W-1:0];
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_item(kind, level[SMP_W-1:0]);
		sent++;
	endtask

	// Stop input, wait for every owed hit, then let the divider settle.
	task automatic wait_drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// cfg_valid stays high across back-to-back writes; caller lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data[SMP_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data[SMP_W-1:0]);
	endtask

	task automatic apply_config(input int thr, input int full, input int win, input int quiet);
		wait_drain();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_FULL_SCALE, full);
		write_reg(REG_WINDOW, win);
		write_reg(REG_QUIET, quiet);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly complete strike / track / mask / release sequences sized to the
	// current window and quiet time, with some raw noise mixed in.
	task automatic run_random(input int budget);
		int start, n, t;
		start = sent;
		while (sent - start < budget) begin
			if ($urandom_range(4, 0) == 0) begin
				n = $urandom_range(10, 1);
				repeat (n) send_item($urandom_range(1, 0), $urandom_range(LVL_MAX, 0));
			end else begin
				n = $urandom_range(3, 0);
				repeat (n) send_item($urandom_range(1, 0), lo_level());
				send_item(KIND_SAMPLE, hi_level());                // strike
				t = sb.win + $urandom_range(2, 0);
				if (t > 0 && $urandom_range(5, 0) == 0)
					t--;                                          // close one tick early
				repeat (t) begin
					if ($urandom_range(7, 0) == 0)
						send_item(KIND_SAMPLE, $urandom_range(LVL_MAX, 0));
					send_item(KIND_TICK, $urandom_range(LVL_MAX, 0));
				end
				send_item(KIND_SAMPLE, $urandom_range(LVL_MAX, 0)); // takes the velocity
				if ($urandom_range(1, 0))
					send_item(KIND_SAMPLE, hi_level());            // retrigger restarts mask timer
				t = sb.quiet + $urandom_range(2, 0);
				repeat (t) begin
					if ($urandom_range(7, 0) == 0)
						send_item(KIND_SAMPLE, lo_level());
					send_item(KIND_TICK, $urandom_range(LVL_MAX, 0));
				end
				send_item(KIND_SAMPLE, lo_level());                // release to idle once past quiet time
			end
		end
	endtask

	initial begin
		int k;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = KIND_SAMPLE;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_THRESHOLD;
		cfg_data      = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset defaults: threshold edge, ignored tick payload,
		// full-scale peak after the window.
		send_item(KIND_SAMPLE, 0);
		send_item(KIND_SAMPLE, THRESHOLD_RST);        // at threshold: stays idle
		send_item(KIND_TICK, LVL_MAX);
		send_item(KIND_SAMPLE, THRESHOLD_RST + 1);    // starts tracking
		repeat (WINDOW_RST) send_item(KIND_TICK, 0);
		send_item(KIND_SAMPLE, LVL_MAX);              // velocity 127

		// zero window and zero quiet time
		wait_drain();
		write_reg(REG_WINDOW, 0);
		write_reg(REG_QUIET, 0);
		@(negedge clk);
		cfg_valid = 1'b0;
		send_item(KIND_TICK, 0);
		send_item(KIND_SAMPLE, 5);                    // back to idle
		send_item(KIND_SAMPLE, THRESHOLD_RST + 1);
		send_item(KIND_SAMPLE, 50);                   // closes at once, velocity 0
		send_item(KIND_TICK, 0);
		send_item(KIND_SAMPLE, 0);
		send_item(KIND_SAMPLE, LVL_MAX);
		send_item(KIND_SAMPLE, 0);                    // closes at once, velocity 127

		// unmapped register indexes must not disturb anything
		wait_drain();
		for (k = 0; k < 4; k++)
			write_reg(CFG_IDX_W'(REG_QUIET + 1 + k), $urandom_range(LVL_MAX, 0));
		@(negedge clk);
		cfg_valid = 1'b0;

		apply_config(THRESHOLD_RST, FULL_SCALE_RST, WINDOW_RST, QUIET_RST);
		run_random(120);
		apply_config(0, LVL_MAX, 1, 1);
		run_random(110);
		apply_config(500, 300, 3, 2);                 // degenerate scale
		run_random(120);
		apply_config($urandom_range(400, 0), $urandom_range(LVL_MAX, 600), 0, 0);
		run_random(200);
		apply_config(50, 900, MS_MAX, MS_MAX - 1);    // long window, timer saturates
		run_random(550);
		apply_config(LVL_MAX, LVL_MAX, 2, MS_MAX);    // nothing can exceed threshold
		run_random(80);
		repeat (5) begin
			apply_config($urandom_range(LVL_MAX, 0), $urandom_range(LVL_MAX, 0),
				($urandom_range(3, 0) << MS_BITS) | $urandom_range(12, 0),
				($urandom_range(3, 0) << MS_BITS) | $urandom_range(12, 0));
			run_random(30);
		end

		// closing stretch at full rate on both sides
		apply_config(THRESHOLD_RST, FULL_SCALE_RST, 4, 4);
		calm = 1'b1;
		run_random(100);

		wait_drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
